[design/kva_pkg.sv]
// Shared types and constants of the key scan voice allocator.
`default_nettype none

package kva_pkg;

    // Keyboard and voice geometry
    localparam int NUM_KEYS       = 64;
    localparam int NUM_BANKS      = 4;
    localparam int NUM_CHANNELS   = 8;
    localparam int NUM_ROWS       = 8;
    localparam int ROW_KEYS       = 8;
    localparam int GATE_BANKS     = NUM_BANKS - 1;
    localparam int FIRST_GATE_KEY = 4;

    // Field widths
    localparam int ROW_W  = 3;
    localparam int KEYS_W = 8;
    localparam int BUSY_W = 24;
    localparam int KIND_W = 2;
    localparam int BANK_W = 2;
    localparam int CHAN_W = 3;
    localparam int NOTE_W = 7;
    localparam int WAVE_W = 2;
    localparam int KEY_W  = 6;
    localparam int OCT_W  = 6;
    localparam int KIDX_W = 3;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 2;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Key phase codes
    localparam logic [1:0] PH_UP   = 2'd0;
    localparam logic [1:0] PH_DOWN = 2'd1;
    localparam logic [1:0] PH_HELD = 2'd2;
    localparam logic [1:0] PH_REL  = 2'd3;

    // Event kinds
    localparam logic [KIND_W-1:0] EV_GATE_ON  = 2'd0;
    localparam logic [KIND_W-1:0] EV_GATE_OFF = 2'd1;
    localparam logic [KIND_W-1:0] EV_WAVE     = 2'd2;

    // Register addresses
    localparam logic [ADDR_W-1:0] ADDR_OCTAVE = 2'd0;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [KEYS_W-1:0] keys;
        logic [BUSY_W-1:0] voice_busy;
    } t_scan;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [BANK_W-1:0] bank;
        logic [CHAN_W-1:0] channel;
        logic [NOTE_W-1:0] note;
        logic [WAVE_W-1:0] wave;
        logic              last;
    } t_event;

    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [ROW_KEYS-1:0] press_mask;
        logic [ROW_KEYS-1:0] rel_mask;
        logic [BUSY_W-1:0]   voice_busy;
        logic                wave_vld;
        logic [WAVE_W-1:0]   wave;
    } t_job;

    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic [CHAN_W-1:0] channel;
    } t_voice;

endpackage

`default_nettype wire

[design/kva_front.sv]
// Front end: key phase machines and classification of one row scan into a job.
`default_nettype none

module kva_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire kva_pkg::t_scan i_scan,
    input  wire logic           i_full,
    output logic                o_push,
    output kva_pkg::t_job       o_job
);

    logic [kva_pkg::NUM_ROWS-1:0][kva_pkg::ROW_KEYS-1:0][1:0] r_phase;
    logic [kva_pkg::ROW_KEYS-1:0][1:0]                         n_row;

    assign o_push = i_valid && !i_full;

    always_comb begin
        logic [1:0]              cur;
        logic [1:0]              nxt;
        logic [kva_pkg::KEY_W:0] key;
        logic                    in_range;
        logic                    gate_ok;
        o_job            = '0;
        o_job.row        = i_scan.row;
        o_job.voice_busy = i_scan.voice_busy;
        for (int k = 0; k < kva_pkg::ROW_KEYS; k++) begin
            cur      = r_phase[i_scan.row][k];
            key      = {1'b0, i_scan.row, kva_pkg::KIDX_W'(k)};
            in_range = key < (kva_pkg::KEY_W + 1)'(kva_pkg::NUM_KEYS);
            gate_ok  = in_range && (key >= (kva_pkg::KEY_W + 1)'(kva_pkg::FIRST_GATE_KEY));
            if (cur == kva_pkg::PH_DOWN || cur == kva_pkg::PH_HELD) begin
                nxt = i_scan.keys[k] ? kva_pkg::PH_HELD : kva_pkg::PH_REL;
            end else begin
                nxt = i_scan.keys[k] ? kva_pkg::PH_DOWN : kva_pkg::PH_UP;
            end
            n_row[k]            = in_range ? nxt : cur;
            o_job.press_mask[k] = gate_ok && (nxt == kva_pkg::PH_DOWN);
            o_job.rel_mask[k]   = gate_ok && (nxt == kva_pkg::PH_REL);
        end
        // lowest fresh press among the wave keys wins
        for (int k = kva_pkg::FIRST_GATE_KEY - 1; k >= 0; k--) begin
            if (i_scan.row == '0 && n_row[k] == kva_pkg::PH_DOWN) begin
                o_job.wave_vld = 1'b1;
                o_job.wave     = kva_pkg::WAVE_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (o_push) begin
            r_phase[i_scan.row] <= n_row;
        end
    end

endmodule

`default_nettype wire

[design/kva_queue.sv]
// Two-entry job queue between the front and back ends.
`default_nettype none

module kva_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire kva_pkg::t_job i_job,
    input  wire logic          i_pop,
    output kva_pkg::t_job      o_job,
    output logic               o_full,
    output logic               o_empty
);

    kva_pkg::t_job               r_mem [kva_pkg::QDEPTH];
    logic [kva_pkg::QPTR_W-1:0]  r_wr;
    logic [kva_pkg::QPTR_W-1:0]  r_rd;
    logic [kva_pkg::QCNT_W-1:0]  r_cnt;

    assign o_full  = r_cnt == kva_pkg::QCNT_W'(kva_pkg::QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == kva_pkg::QPTR_W'(kva_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == kva_pkg::QPTR_W'(kva_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

[design/kva_back.sv]
// Back end: voice allocation, key-to-voice map and event output register.
`default_nettype none

module kva_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_job_vld,
    input  wire kva_pkg::t_job             i_job,
    input  wire logic [kva_pkg::OCT_W-1:0] i_octave,
    input  wire logic                      i_stall,
    output logic                           o_pop,
    output logic                           o_valid,
    output kva_pkg::t_event                o_event
);

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_WAVE  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_KEY0  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_KEYN  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_FLUSH = 4'd9;

    logic [STEP_W-1:0]                                       r_step;
    logic                                                    r_pend_vld;
    kva_pkg::t_event                                         r_pend;
    logic [kva_pkg::GATE_BANKS-1:0][kva_pkg::NUM_CHANNELS-1:0] r_held;
    logic [kva_pkg::NUM_ROWS-1:0][kva_pkg::ROW_KEYS-1:0]     r_vvld;
    kva_pkg::t_voice r_voice [kva_pkg::NUM_ROWS][kva_pkg::ROW_KEYS];
    kva_pkg::t_voice                                         r_cur_v;
    logic                                                    r_out_vld;
    kva_pkg::t_event                                         r_out;

    logic [kva_pkg::KIDX_W-1:0] kidx;
    logic                       is_key;
    logic                       found;
    kva_pkg::t_voice            free_v;
    kva_pkg::t_voice            cur_v;
    logic                       cand_vld;
    logic                       cand_on;
    logic                       cand_off;
    kva_pkg::t_event            cand;
    logic                       slot_free;
    logic                       hold;
    logic                       adv;
    logic                       push;
    kva_pkg::t_event            push_data;
    logic [STEP_W-1:0]          rd_step;
    logic [kva_pkg::KIDX_W-1:0] rd_kidx;

    assign kidx   = kva_pkg::KIDX_W'(r_step - STEP_KEY0);
    assign is_key = (r_step >= STEP_KEY0) && (r_step <= STEP_KEYN);
    assign cur_v  = r_cur_v;

    // Read the voice map one step ahead, so the entry is registered when its key comes up.
    assign rd_step = adv ? ((r_step == STEP_FLUSH) ? STEP_WAVE : r_step + 1'b1) : r_step;
    assign rd_kidx = kva_pkg::KIDX_W'(rd_step - STEP_KEY0);

    // first free voice, bank-major
    always_comb begin
        int   idx;
        logic bsy;
        found  = 1'b0;
        free_v = '0;
        for (int b = 0; b < kva_pkg::GATE_BANKS; b++) begin
            for (int c = 0; c < kva_pkg::NUM_CHANNELS; c++) begin
                idx = b * kva_pkg::NUM_CHANNELS + c;
                bsy = (idx < kva_pkg::BUSY_W) ? i_job.voice_busy[idx] : 1'b0;
                if (!found && !bsy && !r_held[b][c]) begin
                    found          = 1'b1;
                    free_v.bank    = kva_pkg::BANK_W'(b);
                    free_v.channel = kva_pkg::CHAN_W'(c);
                end
            end
        end
    end

    always_comb begin
        cand_on  = is_key && i_job.press_mask[kidx] && found;
        cand_off = is_key && i_job.rel_mask[kidx] && r_vvld[i_job.row][kidx];
        cand_vld = 1'b0;
        cand     = '0;
        if (r_step == STEP_WAVE && i_job.wave_vld) begin
            cand_vld        = 1'b1;
            cand.event_kind = kva_pkg::EV_WAVE;
            cand.wave       = i_job.wave;
        end else if (cand_on) begin
            cand_vld        = 1'b1;
            cand.event_kind = kva_pkg::EV_GATE_ON;
            cand.bank       = free_v.bank;
            cand.channel    = free_v.channel;
            cand.note       = kva_pkg::NOTE_W'({i_job.row, kidx})
                              + kva_pkg::NOTE_W'(i_octave);
        end else if (cand_off) begin
            cand_vld        = 1'b1;
            cand.event_kind = kva_pkg::EV_GATE_OFF;
            cand.bank       = cur_v.bank;
            cand.channel    = cur_v.channel;
        end
    end

    // One result is kept back so that the last one of a scan can be flagged.
    always_comb begin
        slot_free = !r_out_vld || !i_stall;
        if (r_step == STEP_FLUSH) begin
            hold      = r_pend_vld && !slot_free;
            push      = i_job_vld && !hold && r_pend_vld;
            push_data = r_pend;
            push_data.last = 1'b1;
        end else begin
            hold      = cand_vld && r_pend_vld && !slot_free;
            push      = i_job_vld && !hold && cand_vld && r_pend_vld;
            push_data = r_pend;
            push_data.last = 1'b0;
        end
        adv   = i_job_vld && !hold;
        o_pop = adv && (r_step == STEP_FLUSH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= STEP_WAVE;
            r_pend_vld <= 1'b0;
            r_held     <= '0;
            r_vvld     <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (adv) begin
                if (r_step == STEP_FLUSH) begin
                    r_step     <= STEP_WAVE;
                    r_pend_vld <= 1'b0;
                end else begin
                    r_step <= r_step + 1'b1;
                    if (cand_vld) begin
                        r_pend_vld <= 1'b1;
                    end
                end
                if (cand_on) begin
                    r_held[free_v.bank][free_v.channel] <= 1'b1;
                    r_vvld[i_job.row][kidx]             <= 1'b1;
                end else if (cand_off) begin
                    r_held[cur_v.bank][cur_v.channel] <= 1'b0;
                    r_vvld[i_job.row][kidx]           <= 1'b0;
                end
            end
            if (push) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_step != STEP_FLUSH && cand_vld) begin
            r_pend <= cand;
        end
        if (adv && cand_on) begin
            r_voice[i_job.row][kidx] <= free_v;
        end
        r_cur_v <= r_voice[i_job.row][rd_kidx];
        if (push) begin
            r_out <= push_data;
        end
    end

    assign o_valid = r_out_vld;
    assign o_event = r_out;

endmodule

`default_nettype wire

[design/key_scan_voice_allocator_core.sv]
// Top level of the key scan voice allocator: front end, job queue, back end, register port.
//
//   channel   direction  handshake          beat payload
//   scan      in         i_valid / o_stall  i_scan  (row, keys, voice_busy)
//   event     out        o_valid / i_stall  o_event (event_kind, bank, channel, note, wave, last)
//   config    in         APB write/read     octave_offset at byte address 0
//
// The front end takes one scan beat per cycle while the two-entry job queue has room.
// The back end walks each scan through one wave step, one step per key of the row and
// one flush step that emits the held-back final event; output stalls hold the walk.
// Reset (i_rst_n low, synchronous) clears key phases, voice map, owned voices, queue.
// Stalls on the event side back up into the queue and then raise o_stall.
`default_nettype none

module key_scan_voice_allocator_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire kva_pkg::t_scan              i_scan,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output kva_pkg::t_event                  o_event,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [kva_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [kva_pkg::DATA_W-1:0]  pwdata,
    output logic [kva_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);

    logic [kva_pkg::OCT_W-1:0] r_octave;
    logic                      q_push;
    kva_pkg::t_job             q_in;
    kva_pkg::t_job             q_out;
    logic                      q_full;
    logic                      q_empty;
    logic                      q_pop;

    // Register port: zero wait states, octave offset is the only register.
    assign pready = 1'b1;
    assign prdata = (paddr == kva_pkg::ADDR_OCTAVE) ? kva_pkg::DATA_W'(r_octave) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave <= '0;
        end else if (psel && penable && pwrite && pready && paddr == kva_pkg::ADDR_OCTAVE) begin
            r_octave <= pwdata[kva_pkg::OCT_W-1:0];
        end
    end

    // Front end: advance key phases and classify the row into a job.
    kva_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_scan  (i_scan),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_job   (q_in)
    );

    assign o_stall = q_full;

    // Decouple the two ends so either can stall on its own.
    kva_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_job   (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back end: allocate and free voices, emit events one key at a time.
    kva_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job_vld (!q_empty),
        .i_job     (q_out),
        .i_octave  (r_octave),
        .i_stall   (i_stall),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .o_event   (o_event)
    );

endmodule

`default_nettype wire

[design/kva_chk.sv]
// Port-level checks of the key scan voice allocator, bound to the top level.
`default_nettype none

module kva_chk (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            o_stall,
    input wire logic            o_valid,
    input wire logic            i_stall,
    input wire kva_pkg::t_event o_event
);

    // Hold a stalled event beat.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_event))
        else $error("event beat changed while stalled");

    // Drop all pending work on reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs busy after reset");

    // Wave select carries no voice and no note.
    a_wave_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event.event_kind == kva_pkg::EV_WAVE |->
            o_event.bank == '0 && o_event.channel == '0 && o_event.note == '0)
        else $error("wave select with gate fields");

    // Only gate-on carries a note; gate events carry no wave.
    a_gate_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event.event_kind != kva_pkg::EV_WAVE |->
            o_event.wave == '0 &&
            (o_event.event_kind == kva_pkg::EV_GATE_ON || o_event.note == '0))
        else $error("gate event with stray fields");

endmodule

bind key_scan_voice_allocator_core kva_chk u_chk (.*);

`default_nettype wire
